// ----- src/ffra_pkg.sv -----
// Shared types and constants of the first-fit range allocator.
package ffra_pkg;

  // Width of every unit number, length and result on the ports.
  localparam int unsigned UnitW = 11;
  // Map bits held in one memory word, and the bits that address one of them.
  localparam int unsigned WordW = 8;
  localparam int unsigned OffW  = 3;

  localparam logic [UnitW-1:0] RoomReset = 11'd1024;

  localparam logic OpTake    = 1'b0;
  localparam logic OpRelease = 1'b1;

  typedef enum logic {
    PH_SCAN,
    PH_MOD
  } phase_e;

  typedef struct packed {
    logic   load;
    logic   go;
    logic   run;
    phase_e phase;
    logic   clr;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic take;
    logic ok;
    logic clr_last;
    logic scan_found;
    logic scan_end;
    logic mod_done;
  } stat_t;

endpackage

// ----- src/ffra_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ffra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/ffra_ctrl.sv -----
// Sequencing state machine of the first-fit range allocator.
module ffra_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  input  ffra_pkg::stat_t stat_i,
  output ffra_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_MODGO,
    ST_MOD,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    cmd_o.phase = ffra_pkg::PH_SCAN;
    state_d     = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        cmd_o.go    = stat_i.ok;
        cmd_o.phase = stat_i.take ? ffra_pkg::PH_SCAN : ffra_pkg::PH_MOD;
        if (stat_i.ok) begin
          state_d = stat_i.take ? ST_SCAN : ST_MOD;
        end else begin
          state_d = stat_i.take ? ST_RESULT : ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.run = 1'b1;
        if (stat_i.scan_found) begin
          state_d = ST_MODGO;
        end else if (stat_i.scan_end) begin
          state_d = ST_RESULT;
        end
      end
      ST_MODGO: begin
        cmd_o.go    = 1'b1;
        cmd_o.phase = ffra_pkg::PH_MOD;
        state_d     = ST_MOD;
      end
      ST_MOD: begin
        cmd_o.run   = 1'b1;
        cmd_o.phase = ffra_pkg::PH_MOD;
        if (stat_i.mod_done) state_d = stat_i.take ? ST_RESULT : ST_IDLE;
      end
      ST_RESULT: begin
        cmd_o.out_load = !out_valid_q || !out_stall_i;
        if (cmd_o.out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- src/ffra_dp.sv -----
// Datapath of the first-fit range allocator: free map memory, scan and range update.
module ffra_dp #(
  parameter int unsigned MAX_UNITS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ffra_pkg::cmd_t                 cmd_i,
  output ffra_pkg::stat_t                stat_o,
  input  logic                          cfg_we_i,
  input  logic [ffra_pkg::UnitW-1:0]    room_count_i,
  input  logic                          operation_i,
  input  logic [ffra_pkg::UnitW-1:0]    start_req_i,
  input  logic [ffra_pkg::UnitW-1:0]    length_i,
  output logic [ffra_pkg::UnitW-1:0]    first_unit_o
);

  localparam int unsigned UW     = ffra_pkg::UnitW;
  localparam int unsigned WW     = ffra_pkg::WordW;
  localparam int unsigned OW     = ffra_pkg::OffW;
  localparam int unsigned Rows   = (MAX_UNITS + WW - 1) / WW;
  localparam int unsigned AW     = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned CapInt = (MAX_UNITS > 2047) ? 2047 : MAX_UNITS;
  localparam logic [UW-1:0] Cap  = UW'(CapInt);
  localparam logic [AW-1:0] LastRow = AW'(Rows - 1);

  logic [UW-1:0] room_q;
  logic          op_q;
  logic [UW-1:0] len_q, lim_q, lo_q, hi_q, res_q, out_q;
  logic [AW-1:0] last_w_q;
  logic          ok_q;
  logic [UW-1:0] run_q;
  logic [AW-1:0] rd_addr_q, ev_addr_q, clr_q;
  logic          rd_more_q, dv_q;

  // Request decode at acceptance.
  logic [UW-1:0] lim_d;
  logic [UW:0]   rel_last;
  logic          ok_d;

  always_comb begin
    lim_d    = (room_q > Cap) ? Cap : room_q;
    rel_last = {1'b0, start_req_i} + {1'b0, length_i} - {{UW{1'b0}}, 1'b1};
    if (operation_i == ffra_pkg::OpTake) begin
      ok_d = (length_i != '0) && (lim_d != '0);
    end else begin
      ok_d = (start_req_i != '0) && (length_i != '0) && (rel_last <= {1'b0, lim_d});
    end
  end

  // Word bounds of the range being updated.
  logic [UW-1:0] lo_m1, hi_m1;
  logic [AW-1:0] lo_w, hi_w, end_w;
  logic [OW-1:0] lo_off, hi_off;

  assign lo_m1  = lo_q - {{(UW-1){1'b0}}, 1'b1};
  assign hi_m1  = hi_q - {{(UW-1){1'b0}}, 1'b1};
  assign lo_w   = AW'(lo_m1 >> OW);
  assign hi_w   = AW'(hi_m1 >> OW);
  assign lo_off = lo_m1[OW-1:0];
  assign hi_off = hi_m1[OW-1:0];
  assign end_w  = (cmd_i.phase == ffra_pkg::PH_SCAN) ? last_w_q : hi_w;

  // Memory ports.
  logic          rd_en, mod_wr, ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata, rdata, mask, new_word;

  assign rd_en  = cmd_i.run && rd_more_q;
  assign mod_wr = cmd_i.run && (cmd_i.phase == ffra_pkg::PH_MOD) && dv_q;

  always_comb begin
    mask = {WW{1'b1}};
    if (ev_addr_q == lo_w) mask = mask & ({WW{1'b1}} << lo_off);
    if (ev_addr_q == hi_w) mask = mask & ({WW{1'b1}} >> (OW'(WW - 1) - hi_off));
    if (op_q == ffra_pkg::OpRelease) begin
      new_word = rdata | mask;
    end else begin
      new_word = rdata & ~mask;
    end
  end

  assign ram_we    = cmd_i.clr || mod_wr;
  assign ram_waddr = cmd_i.clr ? clr_q : ev_addr_q;
  assign ram_wdata = cmd_i.clr ? {WW{1'b1}} : new_word;

  ffra_ram #(
    .WIDTH(WW),
    .DEPTH(Rows)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr_q),
    .rdata_o(rdata)
  );

  // Run search over one map word: eight short dependent steps.
  logic [UW:0]   base12;
  logic [UW:0]   unit_w [WW];
  logic [UW:0]   cand_w [WW];
  logic [WW-1:0] fbit;
  logic [UW-1:0] run_n;
  logic          found;
  logic [OW-1:0] hit;
  logic          scan_eval;

  always_comb begin
    base12 = ((UW+1)'(ev_addr_q) << OW) + {{UW{1'b0}}, 1'b1};
    for (int j = 0; j < WW; j++) begin
      unit_w[j] = base12 + (UW+1)'(j);
      cand_w[j] = base12 + (UW+1)'(j + 1) - {1'b0, len_q};
      fbit[j]   = rdata[j] && (unit_w[j] <= {1'b0, lim_q});
    end
    run_n = run_q;
    found = 1'b0;
    hit   = '0;
    for (int j = 0; j < WW; j++) begin
      if (!found) begin
        if (fbit[j]) begin
          run_n = run_n + {{(UW-1){1'b0}}, 1'b1};
        end else begin
          run_n = '0;
        end
        if (run_n == len_q) begin
          found = 1'b1;
          hit   = OW'(j);
        end
      end
    end
  end

  assign scan_eval = cmd_i.run && (cmd_i.phase == ffra_pkg::PH_SCAN) && dv_q;

  // Control registers of the read pipeline and the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_q    <= ffra_pkg::RoomReset;
      clr_q     <= '0;
      rd_more_q <= 1'b0;
      dv_q      <= 1'b0;
    end else begin
      if (cfg_we_i) room_q <= room_count_i;
      if (cmd_i.clr) clr_q <= clr_q + {{(AW-1){1'b0}}, 1'b1};
      if (cmd_i.go) begin
        rd_more_q <= 1'b1;
        dv_q      <= 1'b0;
      end else begin
        dv_q <= rd_en;
        if (rd_en && (rd_addr_q == end_w)) rd_more_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= operation_i;
      len_q    <= length_i;
      lim_q    <= lim_d;
      last_w_q <= AW'((lim_d - {{(UW-1){1'b0}}, 1'b1}) >> OW);
      ok_q     <= ok_d;
      lo_q     <= start_req_i;
      hi_q     <= rel_last[UW-1:0];
      res_q    <= '0;
    end
    if (cmd_i.go) begin
      rd_addr_q <= (cmd_i.phase == ffra_pkg::PH_SCAN) ? '0 : lo_w;
      run_q     <= '0;
    end else if (rd_en) begin
      rd_addr_q <= rd_addr_q + {{(AW-1){1'b0}}, 1'b1};
    end
    if (rd_en) ev_addr_q <= rd_addr_q;
    if (scan_eval) begin
      run_q <= run_n;
      if (found) begin
        lo_q  <= cand_w[hit][UW-1:0];
        hi_q  <= unit_w[hit][UW-1:0];
        res_q <= cand_w[hit][UW-1:0];
      end
    end
    if (cmd_i.out_load) out_q <= res_q;
  end

  always_comb begin
    stat_o            = '0;
    stat_o.take       = (op_q == ffra_pkg::OpTake);
    stat_o.ok         = ok_q;
    stat_o.clr_last   = (clr_q == LastRow);
    stat_o.scan_found = scan_eval && found;
    stat_o.scan_end   = scan_eval && !found && (ev_addr_q == last_w_q);
    stat_o.mod_done   = mod_wr && (ev_addr_q == hi_w);
  end

  assign first_unit_o = out_q;

endmodule

// ----- src/first_fit_range_allocator.sv -----
// Top level of the first-fit range allocator: controller, datapath and checks.
//
// The block keeps a free map of units 1..room_count, at most MAX_UNITS. A request
// on the input channel either takes a run (operation 0) of 'length' consecutive
// free units, answered on the output channel with the lowest fitting start or 0,
// or releases start_req..start_req+length-1 and gives no answer. Both channels
// use valid and stall; the room count is written on its own valid/ready port,
// which is always ready, and is meant to change only while the block is idle.
// The map sits in a memory of 8-bit words with a registered read. A take reads
// the map one word a cycle up to the room count, stopping at the first fit,
// then rewrites the words that the run spans; a release rewrites its span.
// A take that finds a run answers its start after the scan and the rewrite; one
// that finds none answers 0, as does one of zero length or with no room, which
// reads no map word. A scan reads at most ceil(room_count / 8) words, 128 at
// 1024 units. A valid release holds the block until its span is rewritten.
// Requests are handled one at a time; the next is taken in the cycle after a
// take hands over its result. After reset a clearing pass sets all the
// ceil(MAX_UNITS / 8) map words, marking every unit free; input stalls until it
// ends. A result waits in the output register while the receiver stalls, and
// the next request is taken meanwhile; a following take holds its result.
module first_fit_range_allocator #(
  parameter int unsigned MAX_UNITS = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ffra_pkg::UnitW-1:0] room_count_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       operation_i,
  input  logic [ffra_pkg::UnitW-1:0] start_req_i,
  input  logic [ffra_pkg::UnitW-1:0] length_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ffra_pkg::UnitW-1:0] first_unit_o
);

  ffra_pkg::cmd_t  cmd;
  ffra_pkg::stat_t stat;

  // The room count register can always take a write.
  assign cfg_ready_o = 1'b1;

  ffra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ffra_dp #(
    .MAX_UNITS(MAX_UNITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .room_count_i(room_count_i),
    .operation_i (operation_i),
    .start_req_i (start_req_i),
    .length_i    (length_i),
    .first_unit_o(first_unit_o)
  );

  // A new result never overwrites one that the receiver has not yet taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && out_stall_i))
    else $error("result loaded over a pending result");

  // No request is accepted while the clearing pass runs.
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> in_stall_o)
    else $error("request accepted during clearing pass");

  // The controller issues at most one kind of command in a cycle.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.go, cmd.run, cmd.clr, cmd.out_load}))
    else $error("conflicting commands");

  // A granted start always lies inside the map.
  a_result_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(first_unit_o) <= MAX_UNITS))
    else $error("result beyond the map");

endmodule

// ----- tb/first_fit_range_allocator_test.sv -----
// Self-checking testbench for the first-fit range allocator, with its own free map model.
`timescale 1ns / 100ps

module first_fit_range_allocator_test;

  localparam int unsigned UnitW = ffra_pkg::UnitW;
  // The map size that the block is built with; the model keeps a map of the same size.
  localparam int unsigned MaxUnits = 1024;
  // A take at the full room count scans 128 words and may rewrite as many again, so
  // SettleCycles covers any request still in flight once its answer has arrived.
  localparam int unsigned SettleCycles = 300;
  // Length of the long hold-off on the output side, and the bound on the final drain.
  localparam int unsigned LongHold = 400;
  localparam int unsigned DrainLimit = 100000;

  typedef struct packed {
    logic [UnitW-1:0] first;
    logic [UnitW-1:0] count;
  } held_run_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [UnitW-1:0] room_count_i = ffra_pkg::RoomReset;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             operation_i = ffra_pkg::OpTake;
  logic [UnitW-1:0] start_req_i = '0;
  logic [UnitW-1:0] length_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [UnitW-1:0] first_unit_o;

  // Model state: one bit per unit, 1 meaning free, and the room count last written.
  bit               unit_free [0:MaxUnits];
  logic [UnitW-1:0] room_setting = ffra_pkg::RoomReset;

  // Answers still owed by the block, oldest first, and the runs that takes have granted.
  logic [UnitW-1:0] expected_first_q [$];
  held_run_t        held_runs [$];

  // Traffic shaping: the sender idles and the receiver stalls with these percentages.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  // The test asks for a long hold-off by raising holds_asked; the receiver serves it.
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;

  int unsigned error_count = 0;

  first_fit_range_allocator #(
    .MAX_UNITS(MaxUnits)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .room_count_i(room_count_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .start_req_i (start_req_i),
    .length_i    (length_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .first_unit_o(first_unit_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Model of the allocator. Units above MaxUnits do not exist, so a larger room
  // count saturates. The map keeps its bits when the room count changes.
  // ---------------------------------------------------------------------------
  function automatic int unsigned usable_units();
    return (32'(room_setting) > MaxUnits) ? MaxUnits : 32'(room_setting);
  endfunction

  // First fit: walk the units upwards, counting the current run of free ones, and
  // take the first run that reaches the length asked for. A zero length takes nothing.
  function automatic logic [UnitW-1:0] grant_run(input logic [UnitW-1:0] count);
    int unsigned limit = usable_units();
    int unsigned run_len = 0;
    int unsigned lo;
    if (count == 0) return '0;
    for (int unsigned u = 1; u <= limit; u++) begin
      if (unit_free[u]) begin
        run_len++;
        if (run_len == count) begin
          lo = u - count + 1;
          for (int unsigned k = lo; k <= u; k++) unit_free[k] = 1'b0;
          return UnitW'(lo);
        end
      end else begin
        run_len = 0;
      end
    end
    return '0;
  endfunction

  // A release with a zero start or length, or one that runs past the room count,
  // leaves the map untouched as a whole. Freeing free units changes nothing.
  function automatic void free_span(input logic [UnitW-1:0] first,
                                    input logic [UnitW-1:0] count);
    int unsigned lo = 32'(first);
    int unsigned last;
    if (first == 0 || count == 0) return;
    last = lo + count - 1;
    if (last > usable_units()) return;
    for (int unsigned k = lo; k <= last; k++) unit_free[k] = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving. Every task is entered just after a falling edge and returns just
  // after one, so inputs always change on the falling edge and the handshake is
  // sampled on the rising edge. The valid of a request that is followed at once
  // by another stays high, and is assigned only once in that time step.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic op, input logic [UnitW-1:0] first,
                              input logic [UnitW-1:0] count);
    logic [UnitW-1:0] granted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    start_req_i <= first;
    length_i    <= count;
    do @(posedge clk_i); while (in_stall_o);
    // The request has been taken at this edge, so the model moves on with it.
    if (op == ffra_pkg::OpTake) begin
      granted = grant_run(count);
      expected_first_q.push_back(granted);
      if (granted != 0) held_runs.push_back('{first: granted, count: count});
    end else begin
      free_span(first, count);
    end
    @(negedge clk_i);
  endtask

  // Stops sending and waits until the block is idle: every answer in, and then long
  // enough for a release, which is never answered, to finish its rewrite.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_first_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Writes the room count; only ever called while the block is idle.
  task automatic set_room(input logic [UnitW-1:0] count);
    cfg_valid_i  <= 1'b1;
    room_count_i <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    room_setting = count;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side. The stall changes on the falling edge. A requested long
  // hold-off is counted here, cycle by cycle, and overrides the random stalls.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        hold_left = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Every answer taken on a rising edge is held against the oldest one owed.
  always @(posedge clk_i) begin : check_answers
    logic [UnitW-1:0] want;
    if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_first_q.size() == 0) begin
        $error("first_unit: no answer expected, got %0d", first_unit_o);
        error_count++;
      end else begin
        want = expected_first_q.pop_front();
        if (first_unit_o !== want) begin
          $error("first_unit: expected %0d, got %0d", want, first_unit_o);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests.
  // ---------------------------------------------------------------------------

  // Takes at the limits of the length field with the full room: a zero length, a
  // single unit, lengths beyond what is free, and a run that exactly fills what is left.
  task automatic test_take_limits();
    settle();
    set_room(ffra_pkg::RoomReset);
    send_request(ffra_pkg::OpTake, 11'd0, 11'd0);
    send_request(ffra_pkg::OpTake, 11'd2047, 11'd1);
    send_request(ffra_pkg::OpTake, 11'd0, 11'd2047);
    send_request(ffra_pkg::OpTake, 11'd5, 11'd1024);
    send_request(ffra_pkg::OpTake, 11'd0, 11'd1023);
    // The map is now full, so even one unit cannot be found.
    send_request(ffra_pkg::OpTake, 11'd0, 11'd1);
  endtask

  // Releases that must be ignored (zero start, zero length, past the room count,
  // all bits set), then releases of the whole map around a take of all of it.
  task automatic test_release_limits();
    send_request(ffra_pkg::OpRelease, 11'd0, 11'd5);
    send_request(ffra_pkg::OpRelease, 11'd5, 11'd0);
    send_request(ffra_pkg::OpRelease, 11'd1020, 11'd10);
    send_request(ffra_pkg::OpRelease, 11'd2047, 11'd2047);
    send_request(ffra_pkg::OpRelease, 11'd1, 11'd1024);
    send_request(ffra_pkg::OpTake, 11'd0, 11'd1024);
    send_request(ffra_pkg::OpRelease, 11'd1, 11'd1024);
  endtask

  // Room counts at the extremes: none at all, a count that saturates at the map
  // size, and a single unit.
  task automatic test_room_limits();
    settle();
    set_room(11'd0);
    send_request(ffra_pkg::OpTake, 11'd0, 11'd1);
    settle();
    set_room(11'd2047);
    send_request(ffra_pkg::OpTake, 11'd0, 11'd1024);
    send_request(ffra_pkg::OpRelease, 11'd1, 11'd1024);
    settle();
    set_room(11'd1);
    send_request(ffra_pkg::OpTake, 11'd0, 11'd1);
    send_request(ffra_pkg::OpTake, 11'd0, 11'd1);
    send_request(ffra_pkg::OpRelease, 11'd2, 11'd1);
    send_request(ffra_pkg::OpRelease, 11'd1, 11'd1);
  endtask

  // A room count that shrinks under units already taken and then grows again: the
  // map keeps its bits, and units above the count can be neither found nor released.
  task automatic test_room_shrink();
    settle();
    set_room(11'd16);
    send_request(ffra_pkg::OpTake, 11'd0, 11'd8);
    settle();
    set_room(11'd4);
    send_request(ffra_pkg::OpTake, 11'd0, 11'd1);
    send_request(ffra_pkg::OpRelease, 11'd5, 11'd4);
    settle();
    set_room(11'd16);
    send_request(ffra_pkg::OpRelease, 11'd5, 11'd4);
    send_request(ffra_pkg::OpTake, 11'd0, 11'd12);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic. Most requests are takes of short runs and releases of runs
  // granted earlier, so that the map fragments and first fit has real work to do;
  // the rest are long takes, zero lengths and releases that are partial, out of
  // range or malformed.
  // ---------------------------------------------------------------------------
  task automatic random_request();
    int unsigned room = usable_units();
    int unsigned roll = $urandom_range(99);
    int unsigned shape = $urandom_range(99);
    int unsigned pick;
    held_run_t   run;
    logic [UnitW-1:0] count;
    if (roll < 55) begin
      if (shape < 70) count = UnitW'($urandom_range(1, (room >= 8) ? room / 8 : 1));
      else if (shape < 85) count = UnitW'($urandom_range(1, room));
      else if (shape < 95) count = UnitW'($urandom_range(2047));
      else count = '0;
      send_request(ffra_pkg::OpTake, UnitW'($urandom_range(2047)), count);
    end else if (roll < 90 && held_runs.size() != 0) begin
      pick = $urandom_range(held_runs.size() - 1);
      run = held_runs[pick];
      held_runs.delete(pick);
      send_request(ffra_pkg::OpRelease, run.first, run.count);
    end else begin
      case (shape % 3)
        0: send_request(ffra_pkg::OpRelease, UnitW'($urandom_range(2047)),
                        UnitW'($urandom_range(2047)));
        1: send_request(ffra_pkg::OpRelease, UnitW'($urandom_range(1, room)),
                        UnitW'($urandom_range(1, 16)));
        default: begin
          if (shape < 50) begin
            send_request(ffra_pkg::OpRelease, 11'd0, UnitW'($urandom_range(2047)));
          end else begin
            send_request(ffra_pkg::OpRelease, UnitW'($urandom_range(2047)), 11'd0);
          end
        end
      endcase
    end
  endtask

  // One block of random requests under a room count of its own.
  task automatic random_block(input int unsigned block_idx, input int unsigned count);
    logic [UnitW-1:0] room;
    case (block_idx)
      0: room = ffra_pkg::RoomReset;
      1: room = 11'd48;
      2: room = 11'd2047;
      3: room = 11'd9;
      4: room = 11'd300;
      5: room = 11'd2;
      6: room = 11'd700;
      default: room = UnitW'($urandom_range(1, 1024));
    endcase
    settle();
    set_room(room);
    repeat (count) random_request();
  endtask

  // Four phases of idling: none, a mostly idle sender, a mostly stalling receiver,
  // and both sides idling now and then.
  task automatic test_random_traffic();
    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 75;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 75;
        end
        default: begin
          send_idle_pct = 29;
          stall_pct = 29;
        end
      endcase
      random_block(2 * phase, 174);
      random_block(2 * phase + 1, 174);
    end
  endtask

  // The receiver holds off for a long stretch while short takes keep coming, so the
  // held answer fills the output register, the next take waits behind it and the
  // block stalls its input until the receiver lets go.
  task automatic test_output_backpressure();
    settle();
    set_room(ffra_pkg::RoomReset);
    send_idle_pct = 0;
    stall_pct = 0;
    holds_asked++;
    repeat (30) send_request(ffra_pkg::OpTake, 11'd0, UnitW'($urandom_range(1, 4)));
  endtask

  initial begin
    for (int unsigned k = 0; k <= MaxUnits; k++) unit_free[k] = 1'b1;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_take_limits();
    test_release_limits();
    test_room_limits();
    test_room_shrink();
    test_random_traffic();
    test_output_backpressure();

    // Drain: the block must answer every take that is still owed within the limit.
    in_valid_i <= 1'b0;
    for (int unsigned wait_cycles = 0;
         wait_cycles < DrainLimit && expected_first_q.size() != 0; wait_cycles++) begin
      @(negedge clk_i);
    end
    if (expected_first_q.size() != 0) begin
      $error("first_unit: %0d answers never arrived", expected_first_q.size());
      error_count++;
    end
    repeat (SettleCycles) @(negedge clk_i);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, which stays under a millisecond.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
src/ffra_pkg.sv
src/ffra_ram.sv
src/ffra_ctrl.sv
src/ffra_dp.sv
src/first_fit_range_allocator.sv
tb/first_fit_range_allocator_test.sv
